// File: src/spcd_pkg.sv
// ============================================================================
// spcd_pkg
// Shared constants and types for the segment closest-point pipeline.
// ============================================================================
package spcd_pkg;

  localparam int AXES = 3;

  // Clamp decision taken once the dot products are known.
  typedef struct packed {
    logic at_start;
    logic at_end;
  } clamp_t;

endpackage

// File: src/spcd_dot.sv
// ============================================================================
// spcd_dot
// Four-stage front end: differences, products, dot-product sums, clamp test.
// ============================================================================
module spcd_dot #(
  parameter int CW = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_hold,
  input  logic [spcd_pkg::AXES-1:0][CW-1:0]        start_pt,
  input  logic [spcd_pkg::AXES-1:0][CW-1:0]        end_pt,
  input  logic [spcd_pkg::AXES-1:0][CW-1:0]        query_pt,
  output logic                                     out_valid,
  input  logic                                     out_hold,
  output logic [2*CW+1:0]                          num,
  output logic [2*CW+1:0]                          den,
  output spcd_pkg::clamp_t                         clamp,
  output logic [spcd_pkg::AXES-1:0][CW-1:0]        start_out,
  output logic [spcd_pkg::AXES-1:0][CW-1:0]        query_out,
  output logic [spcd_pkg::AXES-1:0][CW:0]          dir_out
);
  import spcd_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int SW = 2 * CW + 4;
  localparam int VW = 2 * CW + 2;
  localparam int NS = 4;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic [AXES-1:0][CW-1:0] a1, p1, a2, p2, a3, p3;
  logic [AXES-1:0][DW-1:0] u1, v1, v2, v3;
  logic [AXES-1:0][PW-1:0] uvp2, vvp2;
  logic signed [SW-1:0]    uv3;
  logic [VW-1:0]           vv3;
  logic signed [SW-1:0]    uv_sum;
  logic [VW-1:0]           vv_sum;

  always_comb begin
    en[NS-1] = !vld[NS-1] || !out_hold;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_hold   = !en[0];
  assign out_valid = vld[NS-1];

  always_comb begin
    uv_sum = '0;
    vv_sum = '0;
    for (int k = 0; k < AXES; k++) begin
      uv_sum = uv_sum + SW'($signed(uvp2[k]));
      vv_sum = vv_sum + VW'(vvp2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < AXES; k++) begin
        v1[k] <= DW'($signed(end_pt[k])) - DW'($signed(start_pt[k]));
        u1[k] <= DW'($signed(query_pt[k])) - DW'($signed(start_pt[k]));
      end
      a1 <= start_pt;
      p1 <= query_pt;
    end
    if (en[1]) begin
      for (int k = 0; k < AXES; k++) begin
        uvp2[k] <= PW'($signed(u1[k]) * $signed(v1[k]));
        vvp2[k] <= PW'($signed(v1[k]) * $signed(v1[k]));
      end
      a2 <= a1;
      p2 <= p1;
      v2 <= v1;
    end
    if (en[2]) begin
      uv3 <= uv_sum;
      vv3 <= vv_sum;
      a3  <= a2;
      p3  <= p2;
      v3  <= v2;
    end
    if (en[3]) begin
      clamp.at_start <= (uv3 <= 0);
      clamp.at_end   <= (uv3 > 0) && (uv3 >= $signed({2'b00, vv3}));
      num            <= uv3[VW-1:0];
      den            <= vv3;
      start_out      <= a3;
      query_out      <= p3;
      dir_out        <= v3;
    end
  end

endmodule

// File: src/spcd_div.sv
// ============================================================================
// spcd_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// ============================================================================
module spcd_div #(
  parameter int VW = 34,
  parameter int FB = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_hold,
  input  logic [VW-1:0] num,
  input  logic [VW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  input  logic          out_hold,
  output logic [FB-1:0] quo,
  output logic [SW-1:0] side_out
);
  import spcd_pkg::*;

  logic [FB-1:0] vld;
  logic [FB-1:0] en;

  logic [VW-1:0] rem    [FB];
  logic [VW-1:0] den_r  [FB];
  logic [FB-1:0] q      [FB];
  logic [SW-1:0] side_r [FB];

  logic [VW-1:0] stg_rem  [FB+1];
  logic [VW-1:0] stg_den  [FB+1];
  logic [FB-1:0] stg_q    [FB+1];
  logic [SW-1:0] stg_side [FB+1];
  logic [FB:0]   stg_vld;

  logic [VW:0]   trial  [FB];
  logic [FB-1:0] take;
  logic [VW-1:0] rem_nx [FB];
  logic [FB-1:0] q_nx   [FB];

  always_comb begin
    stg_rem[0]  = num;
    stg_den[0]  = den;
    stg_q[0]    = '0;
    stg_side[0] = side_in;
    stg_vld[0]  = in_valid;
    for (int i = 0; i < FB; i++) begin
      stg_rem[i+1]  = rem[i];
      stg_den[i+1]  = den_r[i];
      stg_q[i+1]    = q[i];
      stg_side[i+1] = side_r[i];
      stg_vld[i+1]  = vld[i];
    end
  end

  always_comb begin
    for (int i = 0; i < FB; i++) begin
      trial[i]  = {stg_rem[i], 1'b0};
      take[i]   = trial[i] >= {1'b0, stg_den[i]};
      rem_nx[i] = take[i] ? VW'(trial[i] - {1'b0, stg_den[i]}) : trial[i][VW-1:0];
      q_nx[i]   = {stg_q[i][FB-2:0], take[i]};
    end
  end

  always_comb begin
    en[FB-1] = !vld[FB-1] || !out_hold;
    for (int i = FB - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_hold   = !en[0];
  assign out_valid = vld[FB-1];
  assign quo       = q[FB-1];
  assign side_out  = side_r[FB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < FB; i++) begin
        if (en[i]) vld[i] <= stg_vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FB; i++) begin
      if (en[i]) begin
        rem[i]    <= rem_nx[i];
        den_r[i]  <= stg_den[i];
        q[i]      <= q_nx[i];
        side_r[i] <= stg_side[i];
      end
    end
  end

endmodule

// File: src/spcd_interp.sv
// ============================================================================
// spcd_interp
// Five-stage back end: offset products, rounding and clamp selection,
// query differences, squares and the final distance sum.
// ============================================================================
module spcd_interp #(
  parameter int CW = 16,
  parameter int FB = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_hold,
  input  logic [FB-1:0]                      frac_q,
  input  spcd_pkg::clamp_t                   clamp,
  input  logic [spcd_pkg::AXES-1:0][CW-1:0]  start_pt,
  input  logic [spcd_pkg::AXES-1:0][CW-1:0]  query_pt,
  input  logic [spcd_pkg::AXES-1:0][CW:0]    dir_pt,
  output logic                               out_valid,
  input  logic                               out_hold,
  output logic [spcd_pkg::AXES-1:0][CW-1:0]  near,
  output logic [FB:0]                        fraction,
  output logic [2*CW+1:0]                    sqr_dist
);
  import spcd_pkg::*;

  localparam int NS = 5;
  localparam int MW = CW + FB;
  localparam int DW = CW + 1;
  localparam int QW = 2 * CW + 2;
  localparam logic [MW:0] HALF    = (MW + 1)'(1) << (FB - 1);
  localparam logic [FB:0] FRAC_ONE = (FB + 1)'(1) << FB;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic [AXES-1:0][CW-1:0] mag;
  logic [AXES-1:0][DW-1:0] negv;
  logic [AXES-1:0][MW:0]   rnd;
  logic [AXES-1:0][CW-1:0] qoff;
  logic [AXES-1:0][DW-1:0] off;
  logic [AXES-1:0][DW-1:0] c_full, b_full;
  logic [AXES-1:0][CW-1:0] c_sel;
  logic [FB:0]             w_sel;
  logic [AXES-1:0][QW-1:0] sq_full;
  logic [QW-1:0]           dist_sum;

  logic [AXES-1:0][MW-1:0] prod1;
  logic [AXES-1:0]         neg1;
  logic [AXES-1:0][CW-1:0] a1, p1;
  logic [AXES-1:0][DW-1:0] v1;
  clamp_t                  clamp1;
  logic [FB-1:0]           w1;

  logic [AXES-1:0][CW-1:0] c2, p2, c3, c4;
  logic [FB:0]             w2, w3, w4;
  logic [AXES-1:0][DW-1:0] d3;
  logic [AXES-1:0][2*CW-1:0] sq4;

  always_comb begin
    en[NS-1] = !vld[NS-1] || !out_hold;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_hold   = !en[0];
  assign out_valid = vld[NS-1];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      negv[k]    = DW'(0) - dir_pt[k];
      mag[k]     = dir_pt[k][CW] ? negv[k][CW-1:0] : dir_pt[k][CW-1:0];
      rnd[k]     = {1'b0, prod1[k]} + HALF;
      qoff[k]    = rnd[k][MW-1:FB];
      off[k]     = neg1[k] ? DW'(0) - {1'b0, qoff[k]} : {1'b0, qoff[k]};
      c_full[k]  = {a1[k][CW-1], a1[k]} + off[k];
      b_full[k]  = {a1[k][CW-1], a1[k]} + v1[k];
      sq_full[k] = QW'($signed(d3[k]) * $signed(d3[k]));
    end
    priority if (clamp1.at_start) begin
      c_sel = a1;
      w_sel = '0;
    end else if (clamp1.at_end) begin
      for (int k = 0; k < AXES; k++) c_sel[k] = b_full[k][CW-1:0];
      w_sel = FRAC_ONE;
    end else begin
      for (int k = 0; k < AXES; k++) c_sel[k] = c_full[k][CW-1:0];
      w_sel = {1'b0, w1};
    end
    dist_sum = '0;
    for (int k = 0; k < AXES; k++) begin
      dist_sum = dist_sum + QW'(sq4[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < AXES; k++) begin
        prod1[k] <= MW'(mag[k]) * MW'(frac_q);
        neg1[k]  <= dir_pt[k][CW];
      end
      a1     <= start_pt;
      p1     <= query_pt;
      v1     <= dir_pt;
      clamp1 <= clamp;
      w1     <= frac_q;
    end
    if (en[1]) begin
      c2 <= c_sel;
      p2 <= p1;
      w2 <= w_sel;
    end
    if (en[2]) begin
      for (int k = 0; k < AXES; k++) begin
        d3[k] <= {p2[k][CW-1], p2[k]} - {c2[k][CW-1], c2[k]};
      end
      c3 <= c2;
      w3 <= w2;
    end
    if (en[3]) begin
      for (int k = 0; k < AXES; k++) begin
        sq4[k] <= sq_full[k][2*CW-1:0];
      end
      c4 <= c3;
      w4 <= w3;
    end
    if (en[4]) begin
      sqr_dist <= dist_sum;
      near     <= c4;
      fraction <= w4;
    end
  end

endmodule

// File: src/segment_point_closest_distance.sv
// Throughput: one item per cycle without out_stall; a divider stage per fraction bit.
// Each stage moves when it is empty or the stage after it moves, so bubbles close up.
// Reset (rst, synchronous) clears every stage's valid bit; data registers keep no reset.
// ============================================================================
// segment_point_closest_distance
// Closest point on a 3D segment to a query point, with the clamped fraction
// along the segment and the squared distance, one item per cycle while out_stall is low.
// ============================================================================
module segment_point_closest_distance #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COORD_BITS-1:0]       start_x,
  input  logic [COORD_BITS-1:0]       start_y,
  input  logic [COORD_BITS-1:0]       start_z,
  input  logic [COORD_BITS-1:0]       end_x,
  input  logic [COORD_BITS-1:0]       end_y,
  input  logic [COORD_BITS-1:0]       end_z,
  input  logic [COORD_BITS-1:0]       query_x,
  input  logic [COORD_BITS-1:0]       query_y,
  input  logic [COORD_BITS-1:0]       query_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [COORD_BITS-1:0]       near_x,
  output logic [COORD_BITS-1:0]       near_y,
  output logic [COORD_BITS-1:0]       near_z,
  output logic [FRACTION_BITS:0]      fraction,
  output logic [2*COORD_BITS+1:0]     sqr_dist
);
  import spcd_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int VW = 2 * CW + 2;
  localparam int SW = $bits(clamp_t) + 2 * AXES * CW + AXES * (CW + 1);
  localparam logic [FB:0] FRAC_ONE = (FB + 1)'(1) << FB;

  logic [AXES-1:0][CW-1:0] start_pt, end_pt, query_pt;

  logic                    dot_valid, dot_hold;
  logic [VW-1:0]           dot_num, dot_den;
  clamp_t                  dot_clamp;
  logic [AXES-1:0][CW-1:0] dot_start, dot_query;
  logic [AXES-1:0][CW:0]   dot_dir;

  logic                    div_valid, div_hold;
  logic [FB-1:0]           div_quo;
  logic [SW-1:0]           div_side;
  clamp_t                  div_clamp;
  logic [AXES-1:0][CW-1:0] div_start, div_query;
  logic [AXES-1:0][CW:0]   div_dir;

  logic [AXES-1:0][CW-1:0] near_pt;

  assign start_pt = {start_z, start_y, start_x};
  assign end_pt   = {end_z, end_y, end_x};
  assign query_pt = {query_z, query_y, query_x};

  spcd_dot #(
    .CW (CW)
  ) u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_hold   (in_stall),
    .start_pt  (start_pt),
    .end_pt    (end_pt),
    .query_pt  (query_pt),
    .out_valid (dot_valid),
    .out_hold  (dot_hold),
    .num       (dot_num),
    .den       (dot_den),
    .clamp     (dot_clamp),
    .start_out (dot_start),
    .query_out (dot_query),
    .dir_out   (dot_dir)
  );

  spcd_div #(
    .VW (VW),
    .FB (FB),
    .SW (SW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dot_valid),
    .in_hold   (dot_hold),
    .num       (dot_num),
    .den       (dot_den),
    .side_in   ({dot_clamp, dot_start, dot_query, dot_dir}),
    .out_valid (div_valid),
    .out_hold  (div_hold),
    .quo       (div_quo),
    .side_out  (div_side)
  );

  assign {div_clamp, div_start, div_query, div_dir} = div_side;

  spcd_interp #(
    .CW (CW),
    .FB (FB)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_hold   (div_hold),
    .frac_q    (div_quo),
    .clamp     (div_clamp),
    .start_pt  (div_start),
    .query_pt  (div_query),
    .dir_pt    (div_dir),
    .out_valid (out_valid),
    .out_hold  (out_stall),
    .near      (near_pt),
    .fraction  (fraction),
    .sqr_dist  (sqr_dist)
  );

  assign near_x = near_pt[0];
  assign near_y = near_pt[1];
  assign near_z = near_pt[2];

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the output side was free.");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("A result was shown right after reset.");

  a_fraction_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fraction <= FRAC_ONE))
    else $error("Fraction beyond one.");

  a_stalled_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable({near_x, near_y, near_z, fraction, sqr_dist})))
    else $error("A stalled result changed or was dropped.");

endmodule

// File: verif/segment_point_closest_distance_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// segment_point_closest_distance_tb
// Drives segment and query-point items into the closest-point pipeline and
// checks every result field against a testbench predictor or the typed rows of
// a directed table of corner cases, sent first. Random items follow under
// several sender and receiver idle mixes, with one long receiver hold-off.
// ============================================================================
module segment_point_closest_distance_tb;

  localparam int COORD_BITS       = 16;
  localparam int FRACTION_BITS    = 16;
  localparam int ONE              = 1 << FRACTION_BITS;
  localparam int RANDOM_ITEMS     = 730;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = FRACTION_BITS + 30;
  localparam int TIME_LIMIT_NS    = 2_000_000;

  typedef enum int {
    KIND_WIDE,
    KIND_LOCAL,
    KIND_FLAT,
    KIND_DEGENERATE,
    KIND_AT_END
  } query_kind_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax, ay, az;
    logic signed [COORD_BITS-1:0] bx, by, bz;
    logic signed [COORD_BITS-1:0] px, py, pz;
  } seg_query_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   nx, ny, nz;
    logic [FRACTION_BITS:0]  frac;
    logic [2*COORD_BITS+1:0] sq_dist;
  } seg_result_t;

  typedef struct packed {
    seg_query_t  query;
    bit          typed;
    seg_result_t result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [COORD_BITS-1:0]   start_x = '0, start_y = '0, start_z = '0;
  logic [COORD_BITS-1:0]   end_x = '0, end_y = '0, end_z = '0;
  logic [COORD_BITS-1:0]   query_x = '0, query_y = '0, query_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [COORD_BITS-1:0]   near_x, near_y, near_z;
  logic [FRACTION_BITS:0]  fraction;
  logic [2*COORD_BITS+1:0] sqr_dist;

  seg_result_t pending_nearest[$];
  dir_row_t    dir_rows[$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_start     = 1'b0;
  bit  recv_hold      = 1'b0;

  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int n_start        = 0;
  int n_end          = 0;
  int n_interior     = 0;
  int n_degenerate   = 0;

  segment_point_closest_distance #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .start_x  (start_x),
    .start_y  (start_y),
    .start_z  (start_z),
    .end_x    (end_x),
    .end_y    (end_y),
    .end_z    (end_z),
    .query_x  (query_x),
    .query_y  (query_y),
    .query_z  (query_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .near_x   (near_x),
    .near_y   (near_y),
    .near_z   (near_z),
    .fraction (fraction),
    .sqr_dist (sqr_dist)
  );

  always #5 clk = ~clk;

  function automatic seg_result_t closest_point_on_segment(seg_query_t q);
    longint a[3], b[3], p[3], v[3], c[3];
    longint uv, vv, d;
    longint unsigned w, rem, mag, off, dist_acc;
    seg_result_t r;
    a[0] = $signed(q.ax); a[1] = $signed(q.ay); a[2] = $signed(q.az);
    b[0] = $signed(q.bx); b[1] = $signed(q.by); b[2] = $signed(q.bz);
    p[0] = $signed(q.px); p[1] = $signed(q.py); p[2] = $signed(q.pz);
    uv = 0;
    vv = 0;
    for (int k = 0; k < 3; k++) begin
      v[k] = b[k] - a[k];
      uv += (p[k] - a[k]) * v[k];
      vv += v[k] * v[k];
    end
    if (uv <= 0) begin
      w = 0;
      c = a;
    end else if (uv >= vv) begin
      w = ONE;
      c = b;
    end else begin
      // Restoring division, one quotient bit per fraction bit, truncated.
      rem = uv;
      w = 0;
      for (int i = 0; i < FRACTION_BITS; i++) begin
        rem = rem << 1;
        w = w << 1;
        if (rem >= longint'(vv)) begin
          rem = rem - vv;
          w = w | 1;
        end
      end
      // Offsets round half away from zero on the magnitude.
      for (int k = 0; k < 3; k++) begin
        mag = (v[k] < 0) ? -v[k] : v[k];
        off = (mag * w + (longint'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        c[k] = (v[k] < 0) ? a[k] - longint'(off) : a[k] + longint'(off);
      end
    end
    dist_acc = 0;
    for (int k = 0; k < 3; k++) begin
      d = p[k] - c[k];
      dist_acc += d * d;
    end
    r.nx      = c[0][COORD_BITS-1:0];
    r.ny      = c[1][COORD_BITS-1:0];
    r.nz      = c[2][COORD_BITS-1:0];
    r.frac    = w[FRACTION_BITS:0];
    r.sq_dist = dist_acc[2*COORD_BITS+1:0];
    return r;
  endfunction

  function automatic dir_row_t make_row(
    input int ax, ay, az, bx, by, bz, px, py, pz,
    input bit typed, input int nx, ny, nz, frac, input longint exp_dist
  );
    dir_row_t row;
    row.query          = '{ax[15:0], ay[15:0], az[15:0], bx[15:0], by[15:0], bz[15:0],
                           px[15:0], py[15:0], pz[15:0]};
    row.typed          = typed;
    row.result.nx      = nx[15:0];
    row.result.ny      = ny[15:0];
    row.result.nz      = nz[15:0];
    row.result.frac    = frac[FRACTION_BITS:0];
    row.result.sq_dist = exp_dist[2*COORD_BITS+1:0];
    return row;
  endfunction

  function automatic seg_query_t random_query();
    query_kind_e kind;
    int pick, span, base, ca[3], cb[3], cp[3];
    seg_query_t q;
    pick = $urandom_range(99);
    if (pick < 25)      kind = KIND_WIDE;
    else if (pick < 65) kind = KIND_LOCAL;
    else if (pick < 80) kind = KIND_FLAT;
    else if (pick < 90) kind = KIND_DEGENERATE;
    else                kind = KIND_AT_END;
    span = 1 << $urandom_range(0, 14);
    for (int k = 0; k < 3; k++) begin
      if (kind == KIND_WIDE) begin
        ca[k] = int'($urandom_range(65535)) - 32768;
        cb[k] = int'($urandom_range(65535)) - 32768;
        cp[k] = int'($urandom_range(65535)) - 32768;
      end else begin
        // Endpoints and query stay close so interior points are common.
        base  = int'($urandom_range(32767)) - 16384;
        ca[k] = base + int'($urandom_range(2 * span)) - span;
        cb[k] = base + int'($urandom_range(2 * span)) - span;
        cp[k] = base + int'($urandom_range(2 * span)) - span;
      end
    end
    if (kind == KIND_FLAT) begin
      ca[2] = 0;
      cb[2] = 0;
      cp[2] = 0;
    end else if (kind == KIND_DEGENERATE) begin
      cb = ca;
    end else if (kind == KIND_AT_END) begin
      if ($urandom_range(1)) cp = cb;
      else cp = ca;
    end
    q = '{ca[0][15:0], ca[1][15:0], ca[2][15:0], cb[0][15:0], cb[1][15:0], cb[2][15:0],
          cp[0][15:0], cp[1][15:0], cp[2][15:0]};
    return q;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic send_query(seg_query_t q, bit typed, seg_result_t typed_result);
    seg_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {start_x, start_y, start_z, end_x, end_y, end_z, query_x, query_y, query_z} <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = typed ? typed_result : closest_point_on_segment(q);
    pending_nearest.push_back(want);
    items_sent++;
    if ({q.ax, q.ay, q.az} == {q.bx, q.by, q.bz}) n_degenerate++;
    else if (want.frac == 0) n_start++;
    else if (want.frac == ONE) n_end++;
    else n_interior++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else if (recv_hold)
      out_stall <= 1'b1;
    else
      out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin : receiver_hold_off
    wait (hold_start);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  always @(posedge clk) begin
    seg_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {near_x, near_y, near_z, fraction, sqr_dist};
      if (pending_nearest.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_nearest.pop_front();
        if (got.nx !== want.nx)
          report_mismatch($sformatf("near_x %0d, expected %0d",
                                    $signed(got.nx), $signed(want.nx)));
        if (got.ny !== want.ny)
          report_mismatch($sformatf("near_y %0d, expected %0d",
                                    $signed(got.ny), $signed(want.ny)));
        if (got.nz !== want.nz)
          report_mismatch($sformatf("near_z %0d, expected %0d",
                                    $signed(got.nz), $signed(want.nz)));
        if (got.frac !== want.frac)
          report_mismatch($sformatf("fraction %0d, expected %0d", got.frac, want.frac));
        if (got.sq_dist !== want.sq_dist)
          report_mismatch($sformatf("sqr_dist %0d, expected %0d",
                                    got.sq_dist, want.sq_dist));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    #(TIME_LIMIT_NS);
    $display("ERROR: timeout with %0d results outstanding", pending_nearest.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int phase_send[4] = '{0, 47, 0, 7};
    int phase_recv[4] = '{0, 0, 47, 7};
    int per_phase;

    // Corner cases: degenerate segments, both clamps at full range, a query
    // past either end, halves in the rounding, and truncation of the fraction.
    dir_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(-32768, -32768, -32768, -32768, -32768, -32768,
                                32767, 32767, 32767,
                                1, -32768, -32768, -32768, 0, 64'd12884508675));
    dir_rows.push_back(make_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                -32768, -32768, -32768, 1, -32768, -32768, -32768, 0, 0));
    dir_rows.push_back(make_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                32767, 32767, 32767, 1, 32767, 32767, 32767, ONE, 0));
    dir_rows.push_back(make_row(32767, 32767, 32767, -32768, -32768, -32768,
                                32767, 32767, 32767, 1, 32767, 32767, 32767, 0, 0));
    dir_rows.push_back(make_row(0, 0, 0, 256, 0, 0, 512, 0, 0, 1, 256, 0, 0, ONE, 65536));
    dir_rows.push_back(make_row(0, 0, 0, 256, 0, 0, -256, 0, 0, 1, 0, 0, 0, 0, 65536));
    dir_rows.push_back(make_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(0, 0, 0, 512, 0, 0, 256, 100, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(0, 0, 0, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(0, 0, 0, -1, -1, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(0, 0, 0, 3, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(0, 0, 0, -3, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767,
                                0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(-1000, 200, 0, 3000, -500, 0, 700, 900, 0,
                                0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(-32768, 0, 32767, 32767, 1, -32768, 1, -32768, 32767,
                                0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(100, 100, 100, 100, 100, 101, -32768, -32768, -32768,
                                0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(-5, 7, -9, 21, -13, 40, 3, 3, 3, 0, 0, 0, 0, 0, 0));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_query(dir_rows[i].query, dir_rows[i].typed, dir_rows[i].result);

    per_phase = RANDOM_ITEMS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      // The receiver holds off at the start of the first phase while items
      // keep coming, so the pipeline fills and pushes back on the input.
      if (ph == 0) hold_start = 1'b1;
      for (int n = 0; n < per_phase; n++)
        send_query(random_query(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items, %0d results checked, one long output hold-off.",
             items_sent, results_seen);
    $display("Clamped at start %0d, at end %0d, interior %0d, degenerate %0d.",
             n_start, n_end, n_interior, n_degenerate);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
